>>> src/lsc_pkg.sv
// shared widths, constants, types and lane weight function for the line sensor centroid
package lsc_pkg;

   // lane count and field widths
   localparam int NumLanes    = 8;
   localparam int LaneWidth   = 3;
   localparam int SampleWidth = 16;
   localparam int MaskWidth   = 8;
   localparam int ErrWidth    = 16;

   // arithmetic widths: darkness 0..4096, darkness sum 0..32768,
   // weighted sum within +-65536, quotient 0..28672
   localparam int DarkWidth  = 13;
   localparam int DsumWidth  = 16;
   localparam int WsumWidth  = 19;
   localparam int MagWidth   = 18;
   localparam int QuotWidth  = 15;
   localparam int StepWidth  = 4;
   localparam int Q12Shift   = 12;

   // request beat layout
   localparam int ReqDataWidth = NumLanes * SampleWidth + MaskWidth;
   localparam int MaskLsb      = NumLanes * SampleWidth;

   // codes and limits
   localparam logic [SampleWidth-1:0] DarkRef  = 16'd4096;
   localparam logic [MaskWidth-1:0]   LostMask = 8'hFF;
   localparam logic [LaneWidth-1:0]   LastLane = 3'd7;
   localparam logic [StepWidth-1:0]   LastStep = 4'd14;
   localparam int                     ErrMax   = 28672;

   typedef logic [SampleWidth-1:0] sample_type;
   typedef sample_type [NumLanes-1:0] sample_arr_type;

   // accumulator result handed to the sequencer
   typedef struct packed {
      logic signed [WsumWidth-1:0] wsum;
      logic        [DsumWidth-1:0] dsum;
   } acc_result_type;

   // weight of a lane: 2*lane - 7, i.e. -7,-5,..,+7 from left to right
   function automatic logic signed [3:0] lane_weight(input logic [LaneWidth-1:0] lane);
      lane_weight = {~lane[2], lane[1:0], 1'b1};
   endfunction

endpackage

>>> src/lsc_accum.sv
// serial darkness and weighted-sum accumulator, one sensor lane per cycle
module lsc_accum (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  lsc_pkg::sample_arr_type samples,
   output logic                    done,
   output lsc_pkg::acc_result_type result
);
   import lsc_pkg::*;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [LaneWidth-1:0]        lane_ff, lane_in;
   sample_arr_type              shreg_ff, shreg_in;
   logic signed [WsumWidth-1:0] wsum_ff, wsum_in;
   logic [DsumWidth-1:0]        dsum_ff, dsum_in;

   logic [DarkWidth-1:0]        dark;
   logic signed [17:0]          prod;

   // darkness of the lane at the head of the shift line, clamped at zero
   always_comb begin
      if (shreg_ff[0] < DarkRef) begin
         dark = DarkWidth'(DarkRef - shreg_ff[0]);
      end else begin
         dark = '0;
      end
      prod = 18'($signed({1'b0, dark})) * 18'(lane_weight(lane_ff));
   end

   // next-state logic
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      lane_in  = lane_ff;
      shreg_in = shreg_ff;
      wsum_in  = wsum_ff;
      dsum_in  = dsum_ff;
      if (start) begin
         busy_in  = 1'b1;
         lane_in  = '0;
         shreg_in = samples;
         wsum_in  = '0;
         dsum_in  = '0;
      end else if (busy_ff) begin
         wsum_in  = wsum_ff + WsumWidth'(prod);
         dsum_in  = dsum_ff + DsumWidth'(dark);
         shreg_in = {SampleWidth'(0), shreg_ff[NumLanes-1:1]};
         lane_in  = lane_ff + 1'b1;
         if (lane_ff == LastLane) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         lane_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         lane_ff <= lane_in;
      end
      shreg_ff <= shreg_in;
      wsum_ff  <= wsum_in;
      dsum_ff  <= dsum_in;
   end

   assign done        = done_ff;
   assign result.wsum = wsum_ff;
   assign result.dsum = dsum_ff;

endmodule

>>> src/lsc_divider.sv
// restoring bit-serial divider: (magnitude << 12) / darkness sum, one quotient bit per cycle
module lsc_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [lsc_pkg::MagWidth-1:0]    magnitude,
   input  logic [lsc_pkg::DsumWidth-1:0]   divisor,
   output logic                            done,
   output logic [lsc_pkg::QuotWidth-1:0]   quotient
);
   import lsc_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [StepWidth-1:0]   step_ff, step_in;
   logic [DsumWidth-1:0]   rem_ff, rem_in;
   logic [QuotWidth-1:0]   num_ff, num_in;
   logic [DsumWidth-1:0]   div_ff, div_in;

   logic [DsumWidth:0]     trial;
   logic [DsumWidth:0]     diff;
   logic                   fits;

   // shared compare and subtract
   always_comb begin
      trial = {rem_ff, num_ff[QuotWidth-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = trial >= {1'b0, div_ff};
   end

   // next-state logic; the quotient bits shift into num as dividend bits leave
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         // quotient stays below 2^15, so the top bits start below the divisor
         rem_in  = DsumWidth'(magnitude[MagWidth-1:3]);
         num_in  = {magnitude[2:0], {Q12Shift{1'b0}}};
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DsumWidth-1:0] : trial[DsumWidth-1:0];
         num_in  = {num_ff[QuotWidth-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

>>> src/line_sensor_centroid.sv
// top level: weighted-centroid line position from eight reflectance sensors
//
//  channel | dir | beat contents
//  --------+-----+--------------------------------------------------------------
//  req_    | in  | tdata: sample_0..sample_7 (16 b each), line_mask (8 b)
//  rsp_    | out | tdata: position_error (16 b signed Q12); tuser: line_seen
//
//  a lost-line beat goes from idle straight to the output state; otherwise the eight
//  lanes are accumulated, then with no dark sensor the sequencer goes straight to
//  the output state, else the serial divider runs, one quotient bit per cycle, and
//  the result is registered at the output; the next beat can be taken once it shows
//  req_tready is high only while the sequencer is idle, one beat at a time
//  a result waits in the output register while the next beat is taken, and a new
//  result waits in the output state while the previous one is still held
//  reset is synchronous and clears the held error to zero
module line_sensor_centroid (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // sample_0 [15:0] .. sample_7 [127:112], line_mask [135:128]
   input  logic [lsc_pkg::ReqDataWidth-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // position_error [15:0]
   output logic [lsc_pkg::ErrWidth-1:0]       rsp_tdata,
   // line_seen [0]
   output logic                               rsp_tuser
);
   import lsc_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ACCUM,
      S_DIV,
      S_OUT
   } state_type;

   state_type                  state_ff, state_in;
   logic signed [ErrWidth-1:0] held_ff, held_in;
   logic                       found_ff, found_in;
   logic                       neg_ff, neg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ErrWidth-1:0]        rsp_data_ff, rsp_data_in;
   logic                       rsp_user_ff, rsp_user_in;

   sample_arr_type             samples;
   logic [MaskWidth-1:0]       line_mask;
   logic                       req_beat;
   logic                       acc_start, acc_done;
   acc_result_type             acc_res;
   logic                       div_start, div_done;
   logic [QuotWidth-1:0]       quot;
   logic [WsumWidth-1:0]       wsum_neg;
   logic [MagWidth-1:0]        mag;
   logic                       out_free;

   // request unpacking
   assign samples   = req_tdata[MaskLsb-1:0];
   assign line_mask = req_tdata[ReqDataWidth-1:MaskLsb];
   assign req_beat  = req_tvalid && req_tready;

   assign acc_start = req_beat && (line_mask != LostMask);
   assign div_start = (state_ff == S_ACCUM) && acc_done && (acc_res.dsum != '0);

   // magnitude of the weighted sum
   always_comb begin
      wsum_neg = -acc_res.wsum;
      mag      = acc_res.wsum[WsumWidth-1] ? wsum_neg[MagWidth-1:0]
                                           : acc_res.wsum[MagWidth-1:0];
   end

   lsc_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .start   (acc_start),
      .samples (samples),
      .done    (acc_done),
      .result  (acc_res)
   );

   lsc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .magnitude (mag),
      .divisor   (acc_res.dsum),
      .done      (div_done),
      .quotient  (quot)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      found_in     = found_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               found_in = (line_mask != LostMask);
               state_in = (line_mask != LostMask) ? S_ACCUM : S_OUT;
            end
         end
         S_ACCUM: begin
            if (acc_done) begin
               neg_in   = acc_res.wsum[WsumWidth-1];
               state_in = (acc_res.dsum == '0) ? S_OUT : S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               held_in  = neg_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = held_ff;
               rsp_user_in  = found_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff    <= found_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // a lost line goes straight to the output state with the seen flag low
   a_lost_skips: assert property (@(posedge clock) disable iff (reset)
      req_beat && (line_mask == LostMask) |=> (state_ff == S_OUT) && !found_ff)
      else $error("lost-line beat did not go straight to output");

   // the held error stays within -7.0 .. +7.0 in Q12
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      (held_ff >= -ErrMax) && (held_ff <= ErrMax))
      else $error("held error out of range");

   // the held error changes only when a division finishes
   a_held_update: assert property (@(posedge clock) disable iff (reset)
      !$stable(held_ff) |-> $past(div_done) && $past(state_ff == S_DIV))
      else $error("held error changed outside division completion");

   // unit completions line up with the sequencer
   a_acc_done: assert property (@(posedge clock) disable iff (reset)
      acc_done |-> (state_ff == S_ACCUM))
      else $error("accumulator finished outside accumulate state");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside divide state");

endmodule
